### hw/rtl/multi_table_cuckoo_lookup_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multi-table cuckoo lookup
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MULTI_TABLE_CUCKOO_LOOKUP_TOP_ASSERT_SVH
`define MULTI_TABLE_CUCKOO_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication
`define MTCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MTCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mtcl_pkg.sv
// ---------------------------------------------------------------------------
// mtcl_pkg
// Shared constants, payload structs and control types of the cuckoo lookup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtcl_pkg;

    localparam int NUM_TABLES       = 2;
    localparam int TABLE_ADDR_WIDTH = 10;
    localparam int TABLE_DEPTH      = 1 << TABLE_ADDR_WIDTH;
    localparam int KEY_WIDTH        = 32;
    localparam int VALUE_WIDTH      = 32;
    localparam int TAG_WIDTH        = 8;
    localparam int HASH_WIDTH       = NUM_TABLES * TABLE_ADDR_WIDTH;
    localparam int SEL_WIDTH        = 1;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } t_op;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_ctrl_state;

    // One input transaction
    typedef struct packed {
        t_op                         op;
        logic [KEY_WIDTH-1:0]        lookup_key;
        logic [HASH_WIDTH-1:0]       lookup_hash;
        logic [TAG_WIDTH-1:0]        user_tag;
        logic [SEL_WIDTH-1:0]        table_select;
        logic [TABLE_ADDR_WIDTH-1:0] entry_index;
        logic                        entry_valid;
        logic [KEY_WIDTH-1:0]        entry_key;
        logic [VALUE_WIDTH-1:0]      entry_value;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic                   found;
        logic [VALUE_WIDTH-1:0] found_value;
        logic [KEY_WIDTH-1:0]   echo_key;
        logic [HASH_WIDTH-1:0]  echo_hash;
        logic [TAG_WIDTH-1:0]   echo_tag;
    } t_out_item;

    // Write request to one table bank
    typedef struct packed {
        logic                        en;
        logic [TABLE_ADDR_WIDTH-1:0] addr;
        logic                        valid;
        logic [KEY_WIDTH-1:0]        key;
        logic [VALUE_WIDTH-1:0]      value;
    } t_bank_wr;

    // Registered read data of one table bank
    typedef struct packed {
        logic                   valid;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
    } t_bank_rd;

    // Controller outputs
    typedef struct packed {
        logic clearing;
        logic run;
    } t_ctrl;

endpackage

### hw/rtl/mtcl_bank.sv
// ---------------------------------------------------------------------------
// mtcl_bank
// One hash table: entry tag store (valid + key) and entry value store,
// one write and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtcl_bank
    import mtcl_pkg::*;
(
    input  logic                        i_clk,
    input  t_bank_wr                    i_wr,
    input  logic                        i_rd_en,
    input  logic [TABLE_ADDR_WIDTH-1:0] i_rd_addr,
    output t_bank_rd                    o_rd
);

    logic [KEY_WIDTH:0]     r_tag_mem [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] r_val_mem [TABLE_DEPTH];
    t_bank_rd               r_rd;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_tag_mem[i_wr.addr] <= {i_wr.valid, i_wr.key};
            r_val_mem[i_wr.addr] <= i_wr.value;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            {r_rd.valid, r_rd.key} <= r_tag_mem[i_rd_addr];
            r_rd.value             <= r_val_mem[i_rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule

### hw/rtl/mtcl_match.sv
// ---------------------------------------------------------------------------
// mtcl_match
// Key compare over all probed entries; highest table index wins.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtcl_match
    import mtcl_pkg::*;
(
    input  t_bank_rd               i_rd [NUM_TABLES],
    input  logic [KEY_WIDTH-1:0]   i_key,
    output logic                   o_found,
    output logic [VALUE_WIDTH-1:0] o_value
);

    // Later tables overwrite earlier hits
    always_comb begin
        o_found = 1'b0;
        o_value = '0;
        for (int t = 0; t < NUM_TABLES; t++) begin
            if (i_rd[t].valid && (i_rd[t].key == i_key)) begin
                o_found = 1'b1;
                o_value = i_rd[t].value;
            end
        end
    end

endmodule

### hw/rtl/multi_table_cuckoo_lookup_top.sv
// Pipeline: a lookup waits in stage 1 for the registered bank read data, then
// moves into the output register when it is free. Throughput: one transaction
// per cycle while results are taken; the banks are probed in parallel, one read
// port per table. Updates give no result. Reset: synchronous, active low; then a
// clearing pass writes every entry invalid, all tables in parallel; no input then.
// ---------------------------------------------------------------------------
// multi_table_cuckoo_lookup_top
// Cuckoo-style key-value lookup over several hash tables held in memories.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_table_cuckoo_lookup_top
    import mtcl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

`include "multi_table_cuckoo_lookup_top_assert.svh"

    t_ctrl_state                 r_state;
    t_ctrl_state                 n_state;
    t_ctrl                       w_ctrl;
    logic [TABLE_ADDR_WIDTH-1:0] r_clr_addr;

    logic                        w_in_accept;
    logic                        w_lookup;
    logic                        w_s1_move;

    logic                        r_s1_valid;
    logic [KEY_WIDTH-1:0]        r_s1_key;
    logic [HASH_WIDTH-1:0]       r_s1_hash;
    logic [TAG_WIDTH-1:0]        r_s1_tag;

    logic                        r_out_valid;
    t_out_item                   r_out_data;

    t_bank_wr                    w_wr [NUM_TABLES];
    t_bank_rd                    w_rd [NUM_TABLES];
    logic                        w_found;
    logic [VALUE_WIDTH-1:0]      w_value;

    // Controller: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) n_state = ST_RUN;
            end
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // Controller: outputs
    always_comb begin
        w_ctrl = '0;
        case (r_state)
            ST_CLEAR: w_ctrl.clearing = 1'b1;
            ST_RUN:   w_ctrl.run      = 1'b1;
            default:  w_ctrl          = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (w_ctrl.clearing) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Handshake; stage 1 drains into the output register when it is free
    assign w_s1_move   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = w_ctrl.run && (!r_s1_valid || w_s1_move);
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_lookup    = w_in_accept && (i_in_data.op == OP_LOOKUP);

    // Table banks; a write and a read never meet on one edge, so no forwarding
    for (genvar t = 0; t < NUM_TABLES; t++) begin : g_bank
        always_comb begin
            if (w_ctrl.clearing) begin
                w_wr[t]      = '0;
                w_wr[t].en   = 1'b1;
                w_wr[t].addr = r_clr_addr;
            end else begin
                w_wr[t].en    = w_in_accept && (i_in_data.op == OP_WRITE)
                                && (i_in_data.table_select == SEL_WIDTH'(t));
                w_wr[t].addr  = i_in_data.entry_index;
                w_wr[t].valid = i_in_data.entry_valid;
                w_wr[t].key   = i_in_data.entry_key;
                w_wr[t].value = i_in_data.entry_value;
            end
        end

        mtcl_bank u_bank (
            .i_clk     (i_clk),
            .i_wr      (w_wr[t]),
            .i_rd_en   (w_lookup),
            .i_rd_addr (i_in_data.lookup_hash[t*TABLE_ADDR_WIDTH +: TABLE_ADDR_WIDTH]),
            .o_rd      (w_rd[t])
        );
    end

    // Stage 1: lookup fields wait for the bank read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_lookup) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lookup) begin
            r_s1_key  <= i_in_data.lookup_key;
            r_s1_hash <= i_in_data.lookup_hash;
            r_s1_tag  <= i_in_data.user_tag;
        end
    end

    mtcl_match u_match (
        .i_rd    (w_rd),
        .i_key   (r_s1_key),
        .o_found (w_found),
        .o_value (w_value)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_data.found       <= w_found;
            r_out_data.found_value <= w_value;
            r_out_data.echo_key    <= r_s1_key;
            r_out_data.echo_hash   <= r_s1_hash;
            r_out_data.echo_tag    <= r_s1_tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    `MTCL_ASSERT_NOW(a_quiet_clear, w_ctrl.clearing, !r_s1_valid && !r_out_valid, "result during clearing pass")
    `MTCL_ASSERT_NEXT(a_lookup_s1, w_lookup, r_s1_valid, "accepted lookup missing in stage 1")
    `MTCL_ASSERT_NEXT(a_s1_hold, r_s1_valid && !w_s1_move, r_s1_valid && $stable(r_s1_key), "stalled stage 1 lost")
    `MTCL_ASSERT_NOW(a_miss_zero, r_out_valid && !r_out_data.found, r_out_data.found_value == '0, "miss with nonzero value")

endmodule

### bench/cuckoo_lookup_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cuckoo_lookup_checker
// Watches both channels of the cuckoo lookup and keeps its own copy of the
// tables. Update transactions write that copy. Each lookup transaction
// queues the result it should produce. Each returned result is compared
// field by field with the oldest queued result.
// ---------------------------------------------------------------------------

module cuckoo_lookup_checker
    import mtcl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_mismatches,
    output int        o_outstanding
);

    // Shadow copy of every table entry
    logic                   slot_valid [NUM_TABLES][TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]   slot_key   [NUM_TABLES][TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] slot_value [NUM_TABLES][TABLE_DEPTH];

    t_out_item expected_results [$];
    int        mismatch_cnt = 0;

    // Probe all tables; a later table overrides an earlier hit
    function automatic t_out_item probe_tables(input t_in_item item);
        t_out_item                   res;
        logic [TABLE_ADDR_WIDTH-1:0] addr;
        int                          t;
        res.found       = 1'b0;
        res.found_value = '0;
        res.echo_key    = item.lookup_key;
        res.echo_hash   = item.lookup_hash;
        res.echo_tag    = item.user_tag;
        for (t = 0; t < NUM_TABLES; t++) begin
            addr = item.lookup_hash[t*TABLE_ADDR_WIDTH +: TABLE_ADDR_WIDTH];
            if (slot_valid[t][addr] && slot_key[t][addr] == item.lookup_key) begin
                res.found       = 1'b1;
                res.found_value = slot_value[t][addr];
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // Track transactions on both channels
    always @(posedge i_clk) begin : monitor
        t_out_item exp_r;
        int        t;
        int        i;
        if (!i_rst_n) begin
            for (t = 0; t < NUM_TABLES; t++) begin
                for (i = 0; i < TABLE_DEPTH; i++) begin
                    slot_valid[t][i] = 1'b0;
                    slot_key[t][i]   = '0;
                    slot_value[t][i] = '0;
                end
            end
            expected_results.delete();
        end else begin
            // results first: a result never belongs to a same-cycle lookup
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no lookup outstanding, echo_key %0h",
                           i_out_data.echo_key);
                    mismatch_cnt++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("found", 64'(exp_r.found), 64'(i_out_data.found));
                    check_field("found_value", 64'(exp_r.found_value),
                                64'(i_out_data.found_value));
                    check_field("echo_key", 64'(exp_r.echo_key),
                                64'(i_out_data.echo_key));
                    check_field("echo_hash", 64'(exp_r.echo_hash),
                                64'(i_out_data.echo_hash));
                    check_field("echo_tag", 64'(exp_r.echo_tag),
                                64'(i_out_data.echo_tag));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.op == OP_WRITE) begin
                    if (int'(i_in_data.table_select) < NUM_TABLES) begin
                        slot_valid[i_in_data.table_select][i_in_data.entry_index] =
                            i_in_data.entry_valid;
                        slot_key[i_in_data.table_select][i_in_data.entry_index] =
                            i_in_data.entry_key;
                        slot_value[i_in_data.table_select][i_in_data.entry_index] =
                            i_in_data.entry_value;
                    end
                end else begin
                    expected_results.push_back(probe_tables(i_in_data));
                end
            end
        end
        o_outstanding <= expected_results.size();
        o_mismatches  <= mismatch_cnt;
    end

endmodule

### bench/tb_multi_table_cuckoo_lookup_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_multi_table_cuckoo_lookup_top
// Drives update and lookup transactions into the cuckoo lookup, with random
// gaps on the input side and random stalls on the result side. A directed
// set covers key and index extremes, invalid entries and hits in both tables.
// The random part targets a small pool of written entries so that most
// lookups hit. The checker beside the block predicts and compares.
// ---------------------------------------------------------------------------

module tb_multi_table_cuckoo_lookup_top;
    import mtcl_pkg::*;

    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_ITEMS = 1525;
    localparam int IDLE_LIMIT   = 5000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;
    int        mismatches;
    int        outstanding;
    bit        no_idle;

    // Entries the random part keeps writing and looking up
    logic [SEL_WIDTH-1:0]        pool_tab [POOL_SIZE];
    logic [TABLE_ADDR_WIDTH-1:0] pool_idx [POOL_SIZE];
    logic [KEY_WIDTH-1:0]        pool_key [POOL_SIZE];

    multi_table_cuckoo_lookup_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    cuckoo_lookup_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 100 MHz clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every field random; callers override what matters
    function automatic t_in_item random_fields();
        t_in_item item;
        item.op           = t_op'($urandom_range(0, 1));
        item.lookup_key   = KEY_WIDTH'($urandom);
        item.lookup_hash  = HASH_WIDTH'($urandom);
        item.user_tag     = TAG_WIDTH'($urandom);
        item.table_select = SEL_WIDTH'($urandom);
        item.entry_index  = TABLE_ADDR_WIDTH'($urandom);
        item.entry_valid  = 1'($urandom);
        item.entry_key    = KEY_WIDTH'($urandom);
        item.entry_value  = VALUE_WIDTH'($urandom);
        return item;
    endfunction

    function automatic t_in_item make_write(input logic [SEL_WIDTH-1:0] tab,
                                            input logic [TABLE_ADDR_WIDTH-1:0] idx,
                                            input logic vld,
                                            input logic [KEY_WIDTH-1:0] key,
                                            input logic [VALUE_WIDTH-1:0] value);
        t_in_item item;
        item              = random_fields();
        item.op           = OP_WRITE;
        item.table_select = tab;
        item.entry_index  = idx;
        item.entry_valid  = vld;
        item.entry_key    = key;
        item.entry_value  = value;
        return item;
    endfunction

    function automatic t_in_item make_lookup(input logic [KEY_WIDTH-1:0] key,
                                             input logic [HASH_WIDTH-1:0] hash,
                                             input logic [TAG_WIDTH-1:0] tag);
        t_in_item item;
        item             = random_fields();
        item.op          = OP_LOOKUP;
        item.lookup_key  = key;
        item.lookup_hash = hash;
        item.user_tag    = tag;
        return item;
    endfunction

    // Optional gap, then hold valid until the transaction is taken
    task automatic send_item(input t_in_item item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        t_in_item item;
        int       n;
        int       r;
        int       s;
        int       b;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        no_idle  = 1'b0;
        for (n = 0; n < POOL_SIZE; n++) begin
            pool_tab[n] = SEL_WIDTH'($urandom);
            pool_idx[n] = TABLE_ADDR_WIDTH'($urandom);
            pool_key[n] = KEY_WIDTH'($urandom);
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // lookups into the cleared tables, key zero included
        send_item(make_lookup(32'h0000_0000, 20'h00000, 8'h00));
        send_item(make_lookup(32'hFFFF_FFFF, 20'hFFFFF, 8'hFF));
        // top index of table 0, then a hit there
        send_item(make_write(1'b0, 10'd1023, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_lookup(32'hFFFF_FFFF, 20'h003FF, 8'h01));
        // same key in table 1: higher table wins
        send_item(make_write(1'b1, 10'd0, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678));
        send_item(make_lookup(32'hFFFF_FFFF, 20'h003FF, 8'h5A));
        // hit with key zero and value zero
        send_item(make_write(1'b0, 10'd0, 1'b1, 32'h0000_0000, 32'h0000_0000));
        send_item(make_lookup(32'h0000_0000, 20'h00000, 8'hA5));
        send_item(make_write(1'b1, 10'd1023, 1'b1, 32'h0000_0000, 32'hA5A5_A5A5));
        send_item(make_lookup(32'h0000_0000, 20'hFFFFF, 8'h80));
        send_item(make_lookup(32'h0000_0000, 20'hFFC00, 8'h7F));
        // matching key but entry marked invalid
        send_item(make_write(1'b0, 10'd5, 1'b0, 32'h0000_0005, 32'h0000_0055));
        send_item(make_lookup(32'h0000_0005, 20'h00005, 8'h02));
        // key off by one bit
        send_item(make_lookup(32'hFFFF_FFFE, 20'h003FF, 8'h03));
        // invalidate table 0 entry, only table 1 remains
        send_item(make_write(1'b0, 10'd1023, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_lookup(32'hFFFF_FFFF, 20'h003FF, 8'h04));
        // overwrite table 1 entry
        send_item(make_write(1'b1, 10'd0, 1'b1, 32'hFFFF_FFFF, 32'h8765_4321));
        send_item(make_lookup(32'hFFFF_FFFF, 20'h003FF, 8'h05));
        // lookup right behind the update of its entry
        no_idle = 1'b1;
        send_item(make_write(1'b0, 10'd77, 1'b1, 32'hDEAD_BEEF, 32'hCAFE_F00D));
        send_item(make_lookup(32'hDEAD_BEEF, 20'h0004D, 8'h06));
        send_item(make_write(1'b1, 10'd512, 1'b1, 32'hDEAD_BEEF, 32'h0BAD_CAFE));
        send_item(make_lookup(32'hDEAD_BEEF, 20'h8004D, 8'h07));
        no_idle = 1'b0;

        // random traffic around the entry pool
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n % 200) >= 150;
            r = $urandom_range(0, 99);
            s = $urandom_range(0, POOL_SIZE - 1);
            if (r < 30) begin
                // write a pool entry, sometimes moved or sharing another key
                if ($urandom_range(0, 9) == 0) begin
                    pool_tab[s] = SEL_WIDTH'($urandom);
                    pool_idx[s] = TABLE_ADDR_WIDTH'($urandom);
                end
                if ($urandom_range(0, 3) == 0)
                    pool_key[s] = pool_key[$urandom_range(0, POOL_SIZE - 1)];
                item = make_write(pool_tab[s], pool_idx[s], $urandom_range(0, 99) < 85,
                                  pool_key[s], VALUE_WIDTH'($urandom));
            end else if (r < 38) begin
                item    = random_fields();
                item.op = OP_WRITE;
            end else if (r < 90) begin
                // lookup aimed at a pool entry, sometimes at two of them
                item = random_fields();
                item.op         = OP_LOOKUP;
                item.lookup_key = pool_key[s];
                item.lookup_hash[int'(pool_tab[s])*TABLE_ADDR_WIDTH +: TABLE_ADDR_WIDTH] =
                    pool_idx[s];
                if (r >= 78) begin
                    b = $urandom_range(0, POOL_SIZE - 1);
                    if (pool_tab[b] != pool_tab[s])
                        item.lookup_hash[int'(pool_tab[b])*TABLE_ADDR_WIDTH +:
                                         TABLE_ADDR_WIDTH] = pool_idx[b];
                end
            end else begin
                item    = random_fields();
                item.op = OP_LOOKUP;
            end
            send_item(item);
        end
        in_valid <= 1'b0;

        // drain and watch for stray results
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side: random stall ahead of each transaction
    initial begin : result_sink
        int stall;
        out_ready = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Watchdog: too long without any transaction
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

endmodule
